// ===== rtl/core/st_pkg.sv =====
`timescale 1ns / 1ps
package st_pkg;

  localparam int MAX_KEYWORD_LEN = 10;
  localparam int NB_AW = $clog2(MAX_KEYWORD_LEN);
  localparam int KW_LW = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int KW_TW = MAX_KEYWORD_LEN * 8;
  localparam int NUM_WORDS = 21;
  localparam int MAX_TOKS = 3;

  typedef enum logic [3:0] {
    M_IDLE, M_OP1, M_COMMENT, M_VAR, M_STR, M_ESC, M_INT, M_INTDOT, M_FLOAT, M_IDENT
  } mode_t;

  typedef logic [5:0] kind_t;

  localparam kind_t K_FATARROW = 6'd0;
  localparam kind_t K_EQEQ     = 6'd1;
  localparam kind_t K_NE       = 6'd2;
  localparam kind_t K_ARROW    = 6'd3;
  localparam kind_t K_SHL      = 6'd4;
  localparam kind_t K_LE       = 6'd5;
  localparam kind_t K_SHR      = 6'd6;
  localparam kind_t K_GE       = 6'd7;
  localparam kind_t K_ANDAND   = 6'd8;
  localparam kind_t K_OROR     = 6'd9;
  localparam kind_t K_LT       = 6'd10;
  localparam kind_t K_GT       = 6'd11;
  localparam kind_t K_LPAREN   = 6'd12;
  localparam kind_t K_RPAREN   = 6'd13;
  localparam kind_t K_LBRACE   = 6'd14;
  localparam kind_t K_RBRACE   = 6'd15;
  localparam kind_t K_LBRACK   = 6'd16;
  localparam kind_t K_RBRACK   = 6'd17;
  localparam kind_t K_COLON    = 6'd18;
  localparam kind_t K_COMMA    = 6'd19;
  localparam kind_t K_PLUS     = 6'd20;
  localparam kind_t K_MINUS    = 6'd21;
  localparam kind_t K_STAR     = 6'd22;
  localparam kind_t K_SLASH    = 6'd23;
  localparam kind_t K_PERCENT  = 6'd24;
  localparam kind_t K_ASSIGN   = 6'd25;
  localparam kind_t K_BANG     = 6'd26;
  localparam kind_t K_DOT      = 6'd27;
  localparam kind_t K_SEMI     = 6'd28;
  localparam kind_t K_VAR      = 6'd29;
  localparam kind_t K_STR      = 6'd30;
  localparam kind_t K_INT      = 6'd31;
  localparam kind_t K_FLOAT    = 6'd32;
  localparam kind_t K_IDENT    = 6'd33;
  localparam kind_t K_UNKNOWN  = 6'd34;
  localparam kind_t K_KW0      = 6'd35;
  localparam kind_t K_EOF      = 6'd56;

  typedef struct packed {
    logic [19:0] line;
    logic [15:0] col;
    logic [23:0] off;
  } pos_t;

  typedef struct packed {
    kind_t       kind;
    pos_t        pos;
    logic [15:0] len;
  } tok_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  pend;
    pos_t        cur;
    pos_t        st;
    logic [15:0] cnt;
    logic        ntl;
  } lex_t;

  localparam pos_t POS_RESET = '{line: 20'd1, col: 16'd1, off: 24'd0};
  localparam lex_t LEX_RESET = '{mode: M_IDLE, pend: 8'd0, cur: POS_RESET,
                                 st: POS_RESET, cnt: 16'd0, ntl: 1'b0};

  localparam logic [KW_LW-1:0] KW_LEN [NUM_WORDS] = '{
    KW_LW'(5), KW_LW'(8), KW_LW'(9), KW_LW'(6), KW_LW'(4), KW_LW'(4), KW_LW'(5),
    KW_LW'(2), KW_LW'(4), KW_LW'(5), KW_LW'(3), KW_LW'(7), KW_LW'(2), KW_LW'(5),
    KW_LW'(3), KW_LW'(6), KW_LW'(7), KW_LW'(9), KW_LW'(10), KW_LW'(4), KW_LW'(2)
  };

  // right-justified text: last character in the low byte
  localparam logic [KW_TW-1:0] KW_TXT [NUM_WORDS] = '{
    KW_TW'("async"), KW_TW'("function"), KW_TW'("Awaitable"), KW_TW'("return"),
    KW_TW'("echo"), KW_TW'("true"), KW_TW'("false"), KW_TW'("if"), KW_TW'("else"),
    KW_TW'("while"), KW_TW'("for"), KW_TW'("foreach"), KW_TW'("as"),
    KW_TW'("class"), KW_TW'("new"), KW_TW'("public"), KW_TW'("private"),
    KW_TW'("interface"), KW_TW'("implements"), KW_TW'("impl"), KW_TW'("__")
  };

endpackage

// ===== rtl/core/st_lexer.sv =====
`timescale 1ns / 1ps
module st_lexer (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          source_byte,
  input  logic                end_of_input,
  output st_pkg::tok_t [st_pkg::MAX_TOKS-1:0] toks,
  output logic [1:0]          tok_cnt
);
  import st_pkg::*;

  lex_t       s;
  lex_t       s_next;
  logic [7:0] nb [MAX_KEYWORD_LEN];
  logic       nb_we;
  logic [NB_AW-1:0] nb_addr;
  logic [7:0] nb_data;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic pos_t pstep(pos_t p, logic nl, logic cc);
    pos_t r;
    r = p;
    if (r.off != '1) r.off = r.off + 24'd1;
    if (nl) begin
      if (r.line != '1) r.line = r.line + 20'd1;
      r.col = 16'd1;
    end else if (cc && r.col != '1) begin
      r.col = r.col + 16'd1;
    end
    return r;
  endfunction

  function automatic lex_t take(lex_t a);
    lex_t r;
    r = a;
    r.cur = pstep(r.cur, 1'b0, 1'b1);
    if (r.cnt != '1) r.cnt = r.cnt + 16'd1;
    return r;
  endfunction

  function automatic logic [6:0] single_kind(logic [7:0] c);
    logic [6:0] k;
    unique case (c)
      "(":     k = {1'b1, K_LPAREN};
      ")":     k = {1'b1, K_RPAREN};
      "{":     k = {1'b1, K_LBRACE};
      "}":     k = {1'b1, K_RBRACE};
      "[":     k = {1'b1, K_LBRACK};
      "]":     k = {1'b1, K_RBRACK};
      ":":     k = {1'b1, K_COLON};
      ",":     k = {1'b1, K_COMMA};
      "+":     k = {1'b1, K_PLUS};
      "*":     k = {1'b1, K_STAR};
      "%":     k = {1'b1, K_PERCENT};
      ".":     k = {1'b1, K_DOT};
      ";":     k = {1'b1, K_SEMI};
      default: k = {1'b0, K_UNKNOWN};
    endcase
    return k;
  endfunction

  function automatic logic is_starter(logic [7:0] c);
    return c == "=" || c == "!" || c == "-" || c == "<" || c == ">" ||
           c == "&" || c == "|" || c == "/";
  endfunction

  function automatic logic [6:0] pair_kind(logic [7:0] p, logic [7:0] c);
    logic [6:0] k;
    priority if (p == "=" && c == ">") k = {1'b1, K_FATARROW};
    else if (p == "=" && c == "=") k = {1'b1, K_EQEQ};
    else if (p == "!" && c == "=") k = {1'b1, K_NE};
    else if (p == "-" && c == ">") k = {1'b1, K_ARROW};
    else if (p == "<" && c == "<") k = {1'b1, K_SHL};
    else if (p == "<" && c == "=") k = {1'b1, K_LE};
    else if (p == ">" && c == ">") k = {1'b1, K_SHR};
    else if (p == ">" && c == "=") k = {1'b1, K_GE};
    else if (p == "&" && c == "&") k = {1'b1, K_ANDAND};
    else if (p == "|" && c == "|") k = {1'b1, K_OROR};
    else k = {1'b0, K_UNKNOWN};
    return k;
  endfunction

  function automatic kind_t alone_kind(logic [7:0] p);
    kind_t k;
    unique case (p)
      "=":     k = K_ASSIGN;
      "!":     k = K_BANG;
      "-":     k = K_MINUS;
      "<":     k = K_LT;
      ">":     k = K_GT;
      "/":     k = K_SLASH;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic kind_t word_kind(lex_t a);
    kind_t k;
    logic  m;
    k = K_IDENT;
    if (!a.ntl && a.cnt <= 16'(MAX_KEYWORD_LEN)) begin
      for (int i = NUM_WORDS - 1; i >= 0; i--) begin
        m = (16'(KW_LEN[i]) == a.cnt);
        for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
          if (j < int'(KW_LEN[i])) begin
            if (nb[j] != KW_TXT[i][(int'(KW_LEN[i]) - 1 - j) * 8 +: 8]) m = 1'b0;
          end
        end
        if (m) k = K_KW0 + kind_t'(i);
      end
    end
    return k;
  endfunction

  function automatic lex_t idle_f(lex_t a, logic [7:0] c, output tok_t t,
                                  output logic e, output logic nbw);
    lex_t       r;
    logic [6:0] sk;
    r = a;
    e = 1'b0;
    nbw = 1'b0;
    sk = single_kind(c);
    t = '{kind: K_UNKNOWN, pos: r.cur, len: 16'd1};
    r.mode = M_IDLE;
    if (c == " " || c == 8'h09 || c == 8'h0d) begin
      r.cur = pstep(r.cur, 1'b0, 1'b1);
    end else if (c == 8'h0a) begin
      r.cur = pstep(r.cur, 1'b1, 1'b0);
    end else if (is_starter(c)) begin
      r.st = r.cur;
      r.cnt = 16'd0;
      r.pend = c;
      r.mode = M_OP1;
    end else if (sk[6]) begin
      t.kind = sk[5:0];
      e = 1'b1;
      r.cur = pstep(r.cur, 1'b0, 1'b1);
    end else begin
      r.st = r.cur;
      r.cnt = 16'd0;
      if (c == "$") begin
        r = take(r);
        r.mode = M_VAR;
      end else if (c == 8'h22) begin
        r = take(r);
        r.mode = M_STR;
      end else if (is_digit(c)) begin
        r = take(r);
        r.mode = M_INT;
      end else if (is_alpha(c) || c == "_") begin
        r.ntl = 1'b0;
        nbw = 1'b1;
        r = take(r);
        r.mode = M_IDENT;
      end else begin
        e = 1'b1;
        r.cur = pstep(r.cur, 1'b0, 1'b1);
      end
    end
    return r;
  endfunction

  always_comb begin
    lex_t       w;
    tok_t       t;
    logic       e;
    logic       nbw;
    logic [6:0] pk;
    w = s;
    t = '0;
    e = 1'b0;
    nbw = 1'b0;
    pk = pair_kind(s.pend, source_byte);
    toks = '0;
    tok_cnt = 2'd0;
    nb_we = 1'b0;
    nb_addr = '0;
    nb_data = source_byte;
    if (end_of_input) begin
      unique case (w.mode)
        M_OP1: begin
          toks[tok_cnt] = '{kind: alone_kind(w.pend), pos: w.st, len: 16'd1};
          tok_cnt = tok_cnt + 2'd1;
          w.cur = pstep(w.cur, 1'b0, 1'b1);
        end
        M_VAR, M_STR, M_ESC, M_INT, M_FLOAT, M_IDENT, M_INTDOT: begin
          priority case (w.mode)
            M_VAR:          t.kind = K_VAR;
            M_STR, M_ESC:   t.kind = K_STR;
            M_FLOAT:        t.kind = K_FLOAT;
            M_IDENT:        t.kind = word_kind(w);
            default:        t.kind = K_INT;
          endcase
          t.pos = w.st;
          t.len = w.cnt;
          toks[tok_cnt] = t;
          tok_cnt = tok_cnt + 2'd1;
          if (w.mode == M_INTDOT) begin
            w = idle_f(w, ".", t, e, nbw);
            if (e) begin
              toks[tok_cnt] = t;
              tok_cnt = tok_cnt + 2'd1;
            end
          end
        end
        default: ;
      endcase
      toks[tok_cnt] = '{kind: K_EOF, pos: w.cur, len: 16'd0};
      tok_cnt = tok_cnt + 2'd1;
      w = LEX_RESET;
    end else begin
      unique case (s.mode)
        M_OP1: begin
          if (s.pend == "/" && source_byte == "/") begin
            w.cur = pstep(pstep(w.cur, 1'b0, 1'b0), 1'b0, 1'b0);
            w.mode = M_COMMENT;
          end else if (pk[6]) begin
            toks[tok_cnt] = '{kind: pk[5:0], pos: w.st, len: 16'd2};
            tok_cnt = tok_cnt + 2'd1;
            w.cur = pstep(pstep(w.cur, 1'b0, 1'b1), 1'b0, 1'b1);
            w.mode = M_IDLE;
          end else begin
            toks[tok_cnt] = '{kind: alone_kind(w.pend), pos: w.st, len: 16'd1};
            tok_cnt = tok_cnt + 2'd1;
            w.cur = pstep(w.cur, 1'b0, 1'b1);
            w = idle_f(w, source_byte, t, e, nbw);
          end
        end
        M_COMMENT: begin
          if (source_byte == 8'h0a) w = idle_f(w, source_byte, t, e, nbw);
          else w.cur = pstep(w.cur, 1'b0, 1'b0);
        end
        M_STR: begin
          w = take(w);
          if (source_byte == 8'h22) begin
            toks[tok_cnt] = '{kind: K_STR, pos: w.st, len: w.cnt};
            tok_cnt = tok_cnt + 2'd1;
            w.mode = M_IDLE;
          end else if (source_byte == 8'h5c) begin
            w.mode = M_ESC;
          end
        end
        M_ESC: begin
          w = take(w);
          w.mode = M_STR;
        end
        M_INT: begin
          if (is_digit(source_byte)) begin
            w = take(w);
          end else if (source_byte == ".") begin
            w.mode = M_INTDOT;
          end else begin
            toks[tok_cnt] = '{kind: K_INT, pos: w.st, len: w.cnt};
            tok_cnt = tok_cnt + 2'd1;
            w = idle_f(w, source_byte, t, e, nbw);
          end
        end
        M_INTDOT: begin
          if (is_digit(source_byte)) begin
            w = take(take(w));
            w.mode = M_FLOAT;
          end else begin
            toks[tok_cnt] = '{kind: K_INT, pos: w.st, len: w.cnt};
            tok_cnt = tok_cnt + 2'd1;
            w = idle_f(w, ".", t, e, nbw);
            if (e) begin
              toks[tok_cnt] = t;
              tok_cnt = tok_cnt + 2'd1;
            end
            w = idle_f(w, source_byte, t, e, nbw);
          end
        end
        M_VAR, M_FLOAT: begin
          if (is_word(source_byte) && (s.mode == M_VAR || is_digit(source_byte))) begin
            w = take(w);
          end else begin
            toks[tok_cnt] = '{kind: (s.mode == M_VAR) ? K_VAR : K_FLOAT,
                              pos: w.st, len: w.cnt};
            tok_cnt = tok_cnt + 2'd1;
            w = idle_f(w, source_byte, t, e, nbw);
          end
        end
        M_IDENT: begin
          if (is_word(source_byte)) begin
            if (w.cnt < 16'(MAX_KEYWORD_LEN)) begin
              nb_we = 1'b1;
              nb_addr = w.cnt[NB_AW-1:0];
            end else begin
              w.ntl = 1'b1;
            end
            w = take(w);
          end else begin
            toks[tok_cnt] = '{kind: word_kind(w), pos: w.st, len: w.cnt};
            tok_cnt = tok_cnt + 2'd1;
            w = idle_f(w, source_byte, t, e, nbw);
          end
        end
        default: begin
          w = idle_f(w, source_byte, t, e, nbw);
        end
      endcase
      if (e) begin
        toks[tok_cnt] = t;
        tok_cnt = tok_cnt + 2'd1;
      end
      if (nbw) begin
        nb_we = 1'b1;
        nb_addr = '0;
      end
    end
    s_next = w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s <= LEX_RESET;
    end else if (accept) begin
      s <= s_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && nb_we) begin
      nb[nb_addr] <= nb_data;
    end
  end

endmodule

// ===== rtl/core/st_outq.sv =====
`timescale 1ns / 1ps
module st_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  st_pkg::tok_t [st_pkg::MAX_TOKS-1:0] toks,
  input  logic [1:0]          tok_cnt,
  output logic                room,
  output logic                tvalid,
  input  logic                tready,
  output st_pkg::tok_t        tok,
  output logic                tlast
);
  import st_pkg::*;

  tok_t [MAX_TOKS-1:0] q;
  logic [1:0] qcnt;
  logic [1:0] qidx;

  assign tvalid = (qidx != qcnt);
  assign tlast  = (qidx + 2'd1 == qcnt);
  assign tok    = q[qidx];
  assign room   = !tvalid || (tready && tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= 2'd0;
      qidx <= 2'd0;
    end else if (load) begin
      qcnt <= tok_cnt;
      qidx <= 2'd0;
    end else if (tvalid && tready) begin
      qidx <= qidx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= toks;
    end
  end

endmodule

// ===== rtl/core/source_tokenizer.sv =====
`timescale 1ns / 1ps
// The first token of an item appears in the cycle after the item is taken.
// Throughput: one item per cycle while items give at most one token and the
// output is ready; an item's extra tokens hold the input until they drain.
// Reset: synchronous, active high; lexer returns to idle at line 1, column 1.
// The end-of-input item also returns the lexer to its reset state.
module source_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] source_byte
  input  logic        s_axis_tuser,  // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] token_kind, [25:6] start_line, [41:26] start_column,
  // [65:42] start_offset, [81:66] token_length, [87:82] zero
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast   // last_of_run
);
  import st_pkg::*;

  tok_t [MAX_TOKS-1:0] toks;
  logic [1:0] tok_cnt;
  logic       accept;
  tok_t       tok;

  assign accept = s_axis_tvalid && s_axis_tready;

  st_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .source_byte  (s_axis_tdata),
    .end_of_input (s_axis_tuser),
    .toks         (toks),
    .tok_cnt      (tok_cnt)
  );

  st_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .toks    (toks),
    .tok_cnt (tok_cnt),
    .room    (s_axis_tready),
    .tvalid  (m_axis_tvalid),
    .tready  (m_axis_tready),
    .tok     (tok),
    .tlast   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, tok.len, tok.pos.off, tok.pos.col, tok.pos.line, tok.kind};

endmodule
